FILE: design/m68k_alu_shift_flags_defines.svh
// assertion macros shared by the checker file
`ifndef M68K_ALU_SHIFT_FLAGS_DEFINES_SVH
`define M68K_ALU_SHIFT_FLAGS_DEFINES_SVH

// same-cycle implication
`define M68K_ASF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m68k_asf assertion failed");

// next-cycle implication
`define M68K_ASF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m68k_asf assertion failed");

`endif

FILE: design/m68k_asf_pkg.sv
// types, codes and size helpers for the alu and shift flag block
`timescale 1ns / 1ps

package m68k_asf_pkg;

   typedef enum logic [3:0] {
      OP_ADD, OP_ADDX, OP_SUB, OP_SUBX, OP_CMP, OP_AND, OP_OR, OP_EOR,
      OP_ASL, OP_ASR, OP_LSL, OP_LSR, OP_ROL, OP_ROR, OP_ROXL, OP_ROXR
   } op_type;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   typedef struct packed {
      logic x;
      logic n;
      logic z;
      logic v;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [31:0] value;
      logic        c;
      logic        v;
   } shift_state_type;

   typedef struct packed {
      logic [31:0] value;
      flags_type   flags;
   } alu_out_type;

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      unique case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_WORD: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] size_msb(input logic [1:0] size);
      logic [31:0] m;
      unique case (size)
         SIZE_BYTE: m = 32'h0000_0080;
         SIZE_WORD: m = 32'h0000_8000;
         default:   m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage

FILE: design/m68k_asf_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface m68k_asf_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [1:0]  size_code;
   logic [31:0] source_operand;
   logic [31:0] target_operand;
   logic [5:0]  shift_count;

   modport source (output valid, req_type, size_code, source_operand, target_operand,
                   shift_count, input ready);
   modport sink (input valid, req_type, size_code, source_operand, target_operand,
                 shift_count, output ready);
endinterface

interface m68k_asf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        flag_carry;
   logic        flag_overflow;
   logic        flag_zero;
   logic        flag_negative;
   logic        flag_extend;

   modport source (output valid, result_value, flag_carry, flag_overflow, flag_zero,
                   flag_negative, flag_extend, input ready);
   modport sink (input valid, result_value, flag_carry, flag_overflow, flag_zero,
                 flag_negative, flag_extend, output ready);
endinterface

FILE: design/m68k_asf_alu.sv
// add, subtract, compare and logic unit with condition codes
`timescale 1ns / 1ps

module m68k_asf_alu (
   input  m68k_asf_pkg::op_type      op,
   input  logic [1:0]                size,
   input  logic [31:0]               src,
   input  logic [31:0]               tgt,
   input  m68k_asf_pkg::flags_type   flags_old,
   output m68k_asf_pkg::alu_out_type alu_out
);
   import m68k_asf_pkg::*;

   logic [31:0] mask;
   logic [31:0] msb;
   logic [31:0] s;
   logic [31:0] t;
   logic [31:0] r;
   logic [32:0] wide;
   logic        ext;
   logic        cin;
   logic        carry;

   always_comb begin
      mask  = size_mask(size);
      msb   = size_msb(size);
      s     = src & mask;
      t     = tgt & mask;
      ext   = (op == OP_ADDX) || (op == OP_SUBX);
      cin   = ext && flags_old.x;
      if ((op == OP_ADD) || (op == OP_ADDX)) begin
         wide = {1'b0, t} + {1'b0, s} + {32'd0, cin};
      end else begin
         wide = {1'b0, t} - {1'b0, s} - {32'd0, cin};
      end
      unique case (size)
         SIZE_BYTE: carry = wide[8];
         SIZE_WORD: carry = wide[16];
         default:   carry = wide[32];
      endcase

      alu_out.flags = flags_old;
      r = wide[31:0] & mask;
      unique case (op)
         OP_ADD, OP_ADDX: begin
            alu_out.flags.c = carry;
            alu_out.flags.v = |(((t ^ r) & (s ^ r)) & msb);
            alu_out.flags.x = carry;
         end
         OP_SUB, OP_SUBX: begin
            alu_out.flags.c = carry;
            alu_out.flags.v = |(((t ^ r) & (s ^ t)) & msb);
            alu_out.flags.x = carry;
         end
         OP_CMP: begin
            alu_out.flags.c = carry;
            alu_out.flags.v = |(((t ^ r) & (s ^ t)) & msb);
         end
         OP_AND: begin
            r = t & s;
            alu_out.flags.c = 1'b0;
            alu_out.flags.v = 1'b0;
         end
         OP_OR: begin
            r = t | s;
            alu_out.flags.c = 1'b0;
            alu_out.flags.v = 1'b0;
         end
         default: begin
            r = t ^ s;
            alu_out.flags.c = 1'b0;
            alu_out.flags.v = 1'b0;
         end
      endcase
      alu_out.value   = r;
      alu_out.flags.z = (r == 32'd0) && (ext ? flags_old.z : 1'b1);
      alu_out.flags.n = |(r & msb);
   end

endmodule

FILE: design/m68k_asf_shift_step.sv
// one-bit shift and rotate step, iterated by the sequencer
`timescale 1ns / 1ps

module m68k_asf_shift_step (
   input  m68k_asf_pkg::op_type          op,
   input  logic [1:0]                    size,
   input  m68k_asf_pkg::shift_state_type st_cur,
   output m68k_asf_pkg::shift_state_type st_next
);
   import m68k_asf_pkg::*;

   logic [31:0] mask;
   logic [31:0] msb;
   logic [31:0] shl;
   logic [31:0] shr;
   logic        hi;
   logic        lo;

   always_comb begin
      mask    = size_mask(size);
      msb     = size_msb(size);
      hi      = |(st_cur.value & msb);
      lo      = st_cur.value[0];
      shl     = (st_cur.value << 1) & mask;
      shr     = st_cur.value >> 1;
      st_next = st_cur;
      unique case (op)
         OP_ASL: begin
            st_next.c     = hi;
            st_next.value = shl;
            st_next.v     = st_cur.v | (|((st_cur.value ^ shl) & msb));
         end
         OP_ASR: begin
            st_next.c     = lo;
            st_next.value = shr | (st_cur.value & msb);
         end
         OP_LSL: begin
            st_next.c     = hi;
            st_next.value = shl;
         end
         OP_LSR: begin
            st_next.c     = lo;
            st_next.value = shr;
         end
         OP_ROL: begin
            st_next.c     = hi;
            st_next.value = shl | {31'd0, hi};
         end
         OP_ROR: begin
            st_next.c     = lo;
            st_next.value = shr | (lo ? msb : 32'd0);
         end
         OP_ROXL: begin
            st_next.c     = hi;
            st_next.value = shl | {31'd0, st_cur.c};
         end
         OP_ROXR: begin
            st_next.c     = lo;
            st_next.value = shr | (st_cur.c ? msb : 32'd0);
         end
         default: st_next = st_cur;
      endcase
   end

endmodule

FILE: design/m68k_alu_shift_flags.sv
// top level: sequencer, condition code register and output register
//
//   channel | direction | payload
//   req_if  | in        | req_type, size_code, source_operand, target_operand, shift_count
//   rsp_if  | out       | result_value, flag_carry/overflow/zero/negative/extend
//
// arithmetic and logic words: exec state, then the finish state loads the output register
// shifts and rotates: exec, then the shift state at one bit per cycle in the step unit, then finish
// ready only while idle; one word in flight at a time
// a finished word waits in the output register while the next request is taken
// synchronous reset clears the sequencer, the output valid and the condition code flags
`timescale 1ns / 1ps

module m68k_alu_shift_flags (
   input logic            clock,
   input logic            reset,
   m68k_asf_req_if.sink   req_if,
   m68k_asf_rsp_if.source rsp_if
);
   import m68k_asf_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SHIFT, ST_FINISH} state_type;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [1:0]      size_ff, size_in;
   logic [31:0]     src_ff, src_in;
   logic [31:0]     tgt_ff, tgt_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic            cnt_nz_ff, cnt_nz_in;
   shift_state_type sh_ff, sh_in;
   flags_type       res_flags_ff, res_flags_in;
   flags_type       flags_ff, flags_in;
   logic [31:0]     out_value_ff, out_value_in;
   flags_type       out_flags_ff, out_flags_in;
   logic            rsp_valid_ff, rsp_valid_in;

   alu_out_type     alu_out;
   shift_state_type sh_next;
   flags_type       sh_flags;
   logic            accept;
   logic            is_rox;

   m68k_asf_alu u_alu (
      .op        (op_ff),
      .size      (size_ff),
      .src       (src_ff),
      .tgt       (tgt_ff),
      .flags_old (flags_ff),
      .alu_out   (alu_out)
   );

   m68k_asf_shift_step u_step (
      .op      (op_ff),
      .size    (size_ff),
      .st_cur  (sh_ff),
      .st_next (sh_next)
   );

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign accept               = req_if.valid && req_if.ready;
   assign is_rox               = (op_ff == OP_ROXL) || (op_ff == OP_ROXR);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result_value  = out_value_ff;
   assign rsp_if.flag_carry    = out_flags_ff.c;
   assign rsp_if.flag_overflow = out_flags_ff.v;
   assign rsp_if.flag_zero     = out_flags_ff.z;
   assign rsp_if.flag_negative = out_flags_ff.n;
   assign rsp_if.flag_extend   = out_flags_ff.x;

   // flags at the end of a shift or rotate
   always_comb begin
      sh_flags   = flags_ff;
      sh_flags.c = sh_ff.c;
      sh_flags.v = (op_ff == OP_ASL) && sh_ff.v;
      sh_flags.z = (sh_ff.value == 32'd0);
      sh_flags.n = |(sh_ff.value & size_msb(size_ff));
      if (is_rox || ((op_ff <= OP_LSR) && cnt_nz_ff)) begin
         sh_flags.x = sh_ff.c;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      cnt_nz_in    = cnt_nz_ff;
      sh_in        = sh_ff;
      res_flags_in = res_flags_ff;
      flags_in     = flags_ff;
      out_value_in = out_value_ff;
      out_flags_in = out_flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_if.req_type);
               size_in   = req_if.size_code;
               src_in    = req_if.source_operand;
               tgt_in    = req_if.target_operand;
               cnt_in    = req_if.shift_count;
               cnt_nz_in = |req_if.shift_count;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff >= OP_ASL) begin
               sh_in.value = tgt_ff & size_mask(size_ff);
               sh_in.c     = is_rox ? flags_ff.x : 1'b0;
               sh_in.v     = 1'b0;
               state_in    = ST_SHIFT;
            end else begin
               sh_in.value  = alu_out.value;
               res_flags_in = alu_out.flags;
               state_in     = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (cnt_ff == 6'd0) begin
               res_flags_in = sh_flags;
               state_in     = ST_FINISH;
            end else begin
               sh_in  = sh_next;
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_value_in = sh_ff.value;
               out_flags_in = res_flags_ff;
               flags_in     = res_flags_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      size_ff      <= size_in;
      src_ff       <= src_in;
      tgt_ff       <= tgt_in;
      cnt_ff       <= cnt_in;
      cnt_nz_ff    <= cnt_nz_in;
      sh_ff        <= sh_in;
      res_flags_ff <= res_flags_in;
      out_value_ff <= out_value_in;
      out_flags_ff <= out_flags_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

FILE: design/m68k_asf_checker.sv
// port-level checker for the alu and shift flag block, with its bind
`timescale 1ns / 1ps
`include "m68k_alu_shift_flags_defines.svh"

module m68k_asf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic        rsp_zero
);

   // a stalled result word holds
   `M68K_ASF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   // busy after taking a word
   `M68K_ASF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // no result appears right after an accept
   `M68K_ASF_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))
   // zero flag only with a zero result
   `M68K_ASF_ASSERT_SAME(a_zero_flag, clock, reset, rsp_valid && rsp_zero, rsp_value == 32'd0)

endmodule

bind m68k_alu_shift_flags m68k_asf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_value (rsp_if.result_value),
   .rsp_zero  (rsp_if.flag_zero)
);

FILE: tb/tb_m68k_alu_shift_flags.sv
// testbench for the 68000 alu and shift condition code block
`timescale 1ns / 1ps

module tb_m68k_alu_shift_flags;
   import m68k_asf_pkg::*;

   localparam logic [1:0] SIZE_LONG  = 2'd2;
   localparam logic [1:0] SIZE_SPARE = 2'd3;

   typedef struct packed {
      op_type      op;
      logic [1:0]  size;
      logic [31:0] src;
      logic [31:0] tgt;
      logic [5:0]  cnt;
   } alu_cmd_type;

   typedef struct {
      alu_cmd_type cmd;
      bit          typed;
      alu_out_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   m68k_asf_req_if req_if ();
   m68k_asf_rsp_if rsp_if ();

   m68k_alu_shift_flags i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   flags_type    cc_flags;
   alu_out_type  alu_results_due[$];
   stim_row_type stim_rows[$];
   int           send_idle_pct;
   int           recv_stall_pct;
   int           fail_count;
   int           words_sent;
   int           results_checked;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic alu_out_type compute_alu_flags(input alu_cmd_type cmd);
      logic [31:0] mask, msb, s, t, r, prev, vacc;
      logic [32:0] wide;
      int          width, i;
      logic        c, v, nx, zk, lo, hi, cin;
      alu_out_type res;
      case (cmd.size)
         SIZE_BYTE: width = 8;
         SIZE_WORD: width = 16;
         default:   width = 32;
      endcase
      mask = 32'hFFFF_FFFF >> (32 - width);
      msb  = 32'h1 << (width - 1);
      s    = cmd.src & mask;
      t    = cmd.tgt & mask;
      c    = 1'b0;
      v    = 1'b0;
      nx   = cc_flags.x;
      r    = '0;
      zk   = 1'b0;
      vacc = '0;
      cin  = (cmd.op == OP_ADDX || cmd.op == OP_SUBX) && cc_flags.x;
      case (cmd.op)
         OP_ADD, OP_ADDX: begin
            wide = {1'b0, t} + {1'b0, s} + {32'd0, cin};
            r    = wide[31:0] & mask;
            v    = |((t ^ r) & (s ^ r) & msb);
            c    = wide[width];
            nx   = c;
            zk   = (cmd.op == OP_ADDX);
         end
         OP_SUB, OP_SUBX, OP_CMP: begin
            wide = {1'b0, t} - {1'b0, s} - {32'd0, cin};
            r    = wide[31:0] & mask;
            v    = |((t ^ r) & (s ^ t) & msb);
            c    = wide[width];
            if (cmd.op != OP_CMP) nx = c;
            zk   = (cmd.op == OP_SUBX);
         end
         OP_AND: r = t & s;
         OP_OR:  r = t | s;
         OP_EOR: r = t ^ s;
         default: begin
            r = t;
            c = (cmd.op == OP_ROXL || cmd.op == OP_ROXR) ? cc_flags.x : 1'b0;
            for (i = 0; i < cmd.cnt; i++) begin
               prev = r;
               lo   = r[0];
               hi   = |(r & msb);
               case (cmd.op)
                  OP_ASL: begin
                     c = hi;
                     r = (r << 1) & mask;
                     vacc |= prev ^ r;
                  end
                  OP_ASR: begin
                     c = lo;
                     r = (r >> 1) | (r & msb);
                  end
                  OP_LSL: begin
                     c = hi;
                     r = (r << 1) & mask;
                  end
                  OP_LSR: begin
                     c = lo;
                     r = r >> 1;
                  end
                  OP_ROL: begin
                     c = hi;
                     r = ((r << 1) & mask) | {31'd0, hi};
                  end
                  OP_ROR: begin
                     c = lo;
                     r = (r >> 1) | (lo ? msb : 32'h0);
                  end
                  OP_ROXL: begin
                     r = ((r << 1) & mask) | {31'd0, c};
                     c = hi;
                  end
                  default: begin
                     r = (r >> 1) | (c ? msb : 32'h0);
                     c = lo;
                  end
               endcase
            end
            v = (cmd.op == OP_ASL) && |(vacc & msb);
            if (cmd.op == OP_ROXL || cmd.op == OP_ROXR) nx = c;
            else if (cmd.op <= OP_LSR && cmd.cnt != 6'd0) nx = c;
         end
      endcase
      res.value   = r;
      res.flags.c = c;
      res.flags.v = v;
      res.flags.z = (r == 32'd0) && (zk ? cc_flags.z : 1'b1);
      res.flags.n = |(r & msb);
      res.flags.x = nx;
      cc_flags = res.flags;
      return res;
   endfunction

   function automatic void add_row(input op_type op, input logic [1:0] size,
                                   input logic [31:0] src, input logic [31:0] tgt,
                                   input logic [5:0] cnt, input bit typed,
                                   input logic [31:0] value, input flags_type fl);
      stim_row_type row;
      row.cmd.op       = op;
      row.cmd.size     = size;
      row.cmd.src      = src;
      row.cmd.tgt      = tgt;
      row.cmd.cnt      = cnt;
      row.typed        = typed;
      row.res.value    = value;
      row.res.flags    = fl;
      stim_rows.push_back(row);
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         4:       return $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic alu_cmd_type random_cmd();
      alu_cmd_type cmd;
      int          sel;
      cmd.op  = op_type'($urandom_range(0, 15));
      sel     = $urandom_range(0, 9);
      cmd.size = (sel < 3) ? SIZE_BYTE : (sel < 6) ? SIZE_WORD :
                 (sel < 9) ? SIZE_LONG : SIZE_SPARE;
      cmd.src = pick_operand();
      cmd.tgt = pick_operand();
      cmd.cnt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                6'($urandom_range(0, 10));
      return cmd;
   endfunction

   function automatic void check_bit(input string name, input logic exp, input logic act);
      if (exp !== act) begin
         $display("%0t: %s expected %b actual %b", $time, name, exp, act);
         fail_count++;
      end
   endfunction

   task automatic send_cmd(input alu_cmd_type cmd, input bit typed,
                           input alu_out_type typed_res);
      alu_out_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.req_type       = cmd.op;
      req_if.size_code      = cmd.size;
      req_if.source_operand = cmd.src;
      req_if.target_operand = cmd.tgt;
      req_if.shift_count    = cmd.cnt;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = compute_alu_flags(cmd);
      alu_results_due.push_back(typed ? typed_res : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      alu_out_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (alu_results_due.size() == 0) begin
            $display("%0t: unexpected result word, actual value %h", $time,
                     rsp_if.result_value);
            fail_count++;
         end else begin
            exp = alu_results_due.pop_front();
            results_checked++;
            if (exp.value !== rsp_if.result_value) begin
               $display("%0t: value expected %h actual %h", $time, exp.value,
                        rsp_if.result_value);
               fail_count++;
            end
            check_bit("carry", exp.flags.c, rsp_if.flag_carry);
            check_bit("overflow", exp.flags.v, rsp_if.flag_overflow);
            check_bit("zero", exp.flags.z, rsp_if.flag_zero);
            check_bit("negative", exp.flags.n, rsp_if.flag_negative);
            check_bit("extend", exp.flags.x, rsp_if.flag_extend);
         end
      end
   end

   initial begin
      int          phase;
      alu_out_type none;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.req_type       = '0;
      req_if.size_code      = '0;
      req_if.source_operand = '0;
      req_if.target_operand = '0;
      req_if.shift_count    = '0;
      rsp_if.ready          = 1'b0;
      cc_flags              = '0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      fail_count            = 0;
      words_sent            = 0;
      results_checked       = 0;
      none                  = '0;

      // flags written as x n z v c
      add_row(OP_ADD,  SIZE_BYTE,  32'h0,         32'h0,         6'd0,  1, 32'h0,        5'b00100);
      add_row(OP_ADD,  SIZE_BYTE,  32'h01,        32'hFF,        6'd0,  1, 32'h0,        5'b10101);
      add_row(OP_ADDX, SIZE_BYTE,  32'h0,         32'h0,         6'd0,  1, 32'h1,        5'b00000);
      add_row(OP_ADD,  SIZE_WORD,  32'h7FFF,      32'h0001,      6'd0,  1, 32'h8000,     5'b01010);
      add_row(OP_SUB,  SIZE_LONG,  32'h1,         32'h0,         6'd0,  1, 32'hFFFF_FFFF, 5'b11001);
      // zero result keeps z cleared
      add_row(OP_SUBX, SIZE_BYTE,  32'h00,        32'h01,        6'd0,  0, 32'h0, 5'b0);
      add_row(OP_ADD,  SIZE_BYTE,  32'h0,         32'h0,         6'd0,  0, 32'h0, 5'b0);
      // zero result keeps z set
      add_row(OP_ADDX, SIZE_BYTE,  32'h0,         32'h0,         6'd0,  0, 32'h0, 5'b0);
      add_row(OP_ADD,  SIZE_BYTE,  32'h01,        32'hFF,        6'd0,  0, 32'h0, 5'b0);
      add_row(OP_SUBX, SIZE_LONG,  32'h0,         32'h0,         6'd0,  0, 32'h0, 5'b0);
      add_row(OP_CMP,  SIZE_WORD,  32'h8000,      32'h7FFF,      6'd0,  0, 32'h0, 5'b0);
      add_row(OP_AND,  SIZE_BYTE,  32'hFFFF_FF0F, 32'h1234_56F3, 6'd0,  0, 32'h0, 5'b0);
      add_row(OP_OR,   SIZE_LONG,  32'hFFFF_FFFF, 32'h0,         6'd0,  0, 32'h0, 5'b0);
      add_row(OP_EOR,  SIZE_WORD,  32'hFFFF,      32'hABCD_FFFF, 6'd0,  0, 32'h0, 5'b0);
      add_row(OP_ASL,  SIZE_BYTE,  32'h0,         32'h40,        6'd1,  0, 32'h0, 5'b0);
      add_row(OP_ASL,  SIZE_LONG,  32'h0,         32'h8000_0001, 6'd63, 0, 32'h0, 5'b0);
      add_row(OP_ASR,  SIZE_WORD,  32'h0,         32'h8000,      6'd20, 0, 32'h0, 5'b0);
      add_row(OP_LSL,  SIZE_LONG,  32'h0,         32'hFFFF_FFFF, 6'd32, 0, 32'h0, 5'b0);
      add_row(OP_LSR,  SIZE_BYTE,  32'h0,         32'h81,        6'd0,  0, 32'h0, 5'b0);
      add_row(OP_ROL,  SIZE_WORD,  32'h0,         32'h8001,      6'd17, 0, 32'h0, 5'b0);
      add_row(OP_ROR,  SIZE_LONG,  32'h0,         32'h0000_0003, 6'd63, 0, 32'h0, 5'b0);
      add_row(OP_ROXL, SIZE_BYTE,  32'h0,         32'h0,         6'd0,  0, 32'h0, 5'b0);
      add_row(OP_ROXL, SIZE_WORD,  32'h0,         32'hFFFF,      6'd17, 0, 32'h0, 5'b0);
      add_row(OP_ROXR, SIZE_BYTE,  32'h0,         32'h01,        6'd9,  0, 32'h0, 5'b0);
      add_row(OP_ADD,  SIZE_SPARE, 32'hFFFF_FFFF, 32'h1,         6'd0,  1, 32'h0,        5'b10101);
      add_row(OP_LSR,  SIZE_SPARE, 32'h0,         32'hFFFF_FFFF, 6'd63, 0, 32'h0, 5'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[k]) send_cmd(stim_rows[k].cmd, stim_rows[k].typed, stim_rows[k].res);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         repeat (175) send_cmd(random_cmd(), 1'b0, none);
      end
      req_if.valid = 1'b0;

      while (alu_results_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("sent %0d words (%0d directed) over all operations and sizes,", words_sent,
               stim_rows.size());
      $display("under four idle and stall patterns; %0d results compared", results_checked);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
